### src/emfd_pkg.sv
// Shared types, constants and codes for the energy meter frame decoder.
// Used by emfd_div and energy_meter_frame_decoder; depends on nothing.
package emfd_pkg;

    // Frame layout
    localparam int unsigned FRAME_LEN = 24;
    localparam int unsigned SR_LEN    = 21;   // bytes 2..22 kept in the shift line
    localparam logic [4:0]  POS_HUNT  = 5'd0;
    localparam logic [4:0]  POS_HDR1  = 5'd1;
    localparam logic [4:0]  POS_FIRST = 5'd2;
    localparam logic [4:0]  POS_CSUM  = 5'd23;
    localparam logic [7:0]  HDR0      = 8'h55;
    localparam logic [7:0]  HDR1      = 8'h5A;

    // Flag bit positions in byte 20
    localparam int unsigned FLAG_V_BIT = 6;
    localparam int unsigned FLAG_I_BIT = 5;
    localparam int unsigned FLAG_P_BIT = 4;

    // Result status codes
    localparam logic [1:0] ST_GOOD  = 2'd0;
    localparam logic [1:0] ST_BADHD = 2'd1;
    localparam logic [1:0] ST_CKSUM = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_VGAIN = 2'd0;
    localparam logic [1:0] CFG_IGAIN = 2'd1;
    localparam logic [1:0] CFG_PGAIN = 2'd2;

    localparam logic [31:0] GAIN_RESET = 32'h0001_0000;
    localparam logic [31:0] Q_MAX      = 32'hFFFF_FFFF;
    localparam logic [47:0] E_MAX      = 48'hFFFF_FFFF_FFFF;

    // Divider: 56-bit dividend, 24-bit divisor, 32 quotient bits, one per cycle
    localparam logic [4:0] DIV_LAST = 5'd31;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_CHECK,
        DV_RUN,
        DV_DONE
    } t_div_state;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_MUL,
        SQ_DIV,
        SQ_EMUL,
        SQ_EADD,
        SQ_EMIT
    } t_seq_state;

    typedef enum logic [1:0] {
        QT_V,
        QT_P,
        QT_I
    } t_qty;

    typedef struct packed {
        logic        start;
        logic [55:0] num;
        logic [23:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } t_div_rsp;

endpackage

### src/emfd_div.sv
// Iterative restoring divider, one quotient bit per cycle, with saturation.
// Depends on emfd_pkg (request/response structs, state enum, DIV_LAST, Q_MAX).
module emfd_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  emfd_pkg::t_div_req i_req,
    output emfd_pkg::t_div_rsp o_rsp
);

    emfd_pkg::t_div_state r_state, n_state;
    logic [23:0] r_rem;
    logic [23:0] r_den;
    logic [31:0] r_q;      // dividend low bits shift out, quotient bits shift in
    logic [4:0]  r_cnt;

    logic [24:0] w_trial;
    logic        w_ge;
    logic        w_sat;

    // Quotient overflows 32 bits iff the upper dividend part reaches the
    // divisor; a zero divisor always lands here too.
    assign w_sat   = (r_rem >= r_den);
    assign w_trial = {r_rem, r_q[31]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            emfd_pkg::DV_IDLE:  if (i_req.start) n_state = emfd_pkg::DV_CHECK;
            emfd_pkg::DV_CHECK: n_state = w_sat ? emfd_pkg::DV_DONE : emfd_pkg::DV_RUN;
            emfd_pkg::DV_RUN:   if (r_cnt == emfd_pkg::DIV_LAST) n_state = emfd_pkg::DV_DONE;
            emfd_pkg::DV_DONE:  n_state = emfd_pkg::DV_IDLE;
            default:            n_state = emfd_pkg::DV_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_rsp.done = (r_state == emfd_pkg::DV_DONE);
        o_rsp.quot = r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= emfd_pkg::DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            emfd_pkg::DV_IDLE: begin
                if (i_req.start) begin
                    r_rem <= i_req.num[55:32];
                    r_q   <= i_req.num[31:0];
                    r_den <= i_req.den;
                end
            end
            emfd_pkg::DV_CHECK: begin
                r_cnt <= '0;
                if (w_sat) begin
                    r_q <= emfd_pkg::Q_MAX;
                end
            end
            emfd_pkg::DV_RUN: begin
                r_cnt <= r_cnt + 5'd1;
                r_q   <= {r_q[30:0], w_ge};
                if (w_ge) begin
                    r_rem <= 24'(w_trial - {1'b0, r_den});
                end else begin
                    r_rem <= w_trial[23:0];
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### src/energy_meter_frame_decoder.sv
// Energy meter frame decoder top level: framing, checksum, sequencer, energy.
// Depends on emfd_pkg and instantiates emfd_div.
//
// Bytes of a 24-byte meter frame (0x55 0x5A header, checksum in the last byte)
// are taken one per cycle while o_stall is low. A bad second header byte or a
// checksum mismatch sends the sequencer to its emit state, which places an
// error transaction in the output register. The last byte of a good frame
// starts the sequencer, which holds o_stall high until it is done: each of
// voltage, power and current takes a multiply step and a division on the
// single shared 32-step divider (a skipped quantity spends only its multiply
// step, a saturating division ends without the 32 steps), then the energy
// update runs its multiply and add states and the sequencer waits in its emit
// state until the output register is free to take the result. Results wait in
// that register while the next bytes are taken.
module energy_meter_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_voltage,
    output logic [31:0] o_current,
    output logic [31:0] o_power,
    output logic [47:0] o_energy,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    emfd_pkg::t_seq_state r_state, n_state;
    emfd_pkg::t_qty       r_qty;

    logic [31:0] r_vgain, r_igain, r_pgain;
    logic [4:0]  r_pos;
    logic [7:0]  r_sum;
    logic [7:0]  r_sr [emfd_pkg::SR_LEN];
    logic [1:0]  r_status;
    logic [31:0] r_v, r_i, r_p;
    logic [15:0] r_last;
    logic [47:0] r_energy;
    logic [39:0] r_prod;

    logic        r_o_valid;
    logic [1:0]  r_o_status;
    logic [31:0] r_o_v, r_o_i, r_o_p;
    logic [47:0] r_o_energy;

    logic        w_acc;
    logic        w_hunt;
    logic        w_bad_hdr;
    logic        w_last;
    logic        w_cs_ok;
    logic        w_en;
    logic        w_out_load;
    logic [7:0]  w_flags;
    logic [23:0] w_coef_v, w_cyc_v, w_coef_i, w_cyc_i, w_coef_p, w_cyc_p;
    logic [15:0] w_cnt, w_last_eff, w_delta;
    logic [31:0] w_mul_a;
    logic [23:0] w_mul_b;
    logic [23:0] w_den;
    logic [55:0] w_prod;
    logic [48:0] w_esum;

    emfd_pkg::t_div_req w_div_req;
    emfd_pkg::t_div_rsp w_div_rsp;

    // Frame fields at fixed taps: byte k of the frame sits at r_sr[22-k]
    assign w_coef_v = {r_sr[20], r_sr[19], r_sr[18]};
    assign w_cyc_v  = {r_sr[17], r_sr[16], r_sr[15]};
    assign w_coef_i = {r_sr[14], r_sr[13], r_sr[12]};
    assign w_cyc_i  = {r_sr[11], r_sr[10], r_sr[9]};
    assign w_coef_p = {r_sr[8],  r_sr[7],  r_sr[6]};
    assign w_cyc_p  = {r_sr[5],  r_sr[4],  r_sr[3]};
    assign w_flags  = r_sr[2];
    assign w_cnt    = {r_sr[1],  r_sr[0]};

    // Byte classification
    assign w_acc     = i_valid && !o_stall;
    assign w_hunt    = (r_pos == emfd_pkg::POS_HUNT) || (r_pos > emfd_pkg::POS_CSUM);
    assign w_bad_hdr = (r_pos == emfd_pkg::POS_HDR1) && (i_rx_byte != emfd_pkg::HDR1);
    assign w_last    = (r_pos == emfd_pkg::POS_CSUM);
    assign w_cs_ok   = (r_sum == i_rx_byte);

    // Pulse counter delta; first sighting gives zero
    assign w_last_eff = (r_last == 16'd0) ? w_cnt : r_last;
    assign w_delta    = w_cnt - w_last_eff;

    // Quantity enable and shared multiplier operands
    always_comb begin
        w_en    = 1'b0;
        w_mul_a = r_vgain;
        w_mul_b = w_coef_v;
        w_den   = w_cyc_v;
        case (r_qty)
            emfd_pkg::QT_V: begin
                w_en    = w_flags[emfd_pkg::FLAG_V_BIT];
                w_mul_a = r_vgain;
                w_mul_b = w_coef_v;
                w_den   = w_cyc_v;
            end
            emfd_pkg::QT_P: begin
                w_en    = w_flags[emfd_pkg::FLAG_P_BIT];
                w_mul_a = r_pgain;
                w_mul_b = w_coef_p;
                w_den   = w_cyc_p;
            end
            emfd_pkg::QT_I: begin
                w_en    = w_flags[emfd_pkg::FLAG_I_BIT] && (r_p != 32'd0);
                w_mul_a = r_igain;
                w_mul_b = w_coef_i;
                w_den   = w_cyc_i;
            end
            default: begin
            end
        endcase
        if (r_state == emfd_pkg::SQ_EMUL) begin
            w_mul_a = {16'd0, w_delta};
            w_mul_b = w_coef_p;
        end
    end

    assign w_prod = w_mul_a * w_mul_b;
    assign w_esum = {1'b0, r_energy} + {9'd0, r_prod};

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            emfd_pkg::SQ_IDLE: begin
                if (w_acc && w_bad_hdr) begin
                    n_state = emfd_pkg::SQ_EMIT;
                end else if (w_acc && w_last) begin
                    n_state = w_cs_ok ? emfd_pkg::SQ_MUL : emfd_pkg::SQ_EMIT;
                end
            end
            emfd_pkg::SQ_MUL: begin
                if (w_en) begin
                    n_state = emfd_pkg::SQ_DIV;
                end else if (r_qty == emfd_pkg::QT_I) begin
                    n_state = emfd_pkg::SQ_EMUL;
                end
            end
            emfd_pkg::SQ_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = (r_qty == emfd_pkg::QT_I) ? emfd_pkg::SQ_EMUL
                                                        : emfd_pkg::SQ_MUL;
                end
            end
            emfd_pkg::SQ_EMUL: n_state = emfd_pkg::SQ_EADD;
            emfd_pkg::SQ_EADD: n_state = emfd_pkg::SQ_EMIT;
            emfd_pkg::SQ_EMIT: if (w_out_load) n_state = emfd_pkg::SQ_IDLE;
            default:           n_state = emfd_pkg::SQ_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_stall         = (r_state != emfd_pkg::SQ_IDLE);
        w_out_load      = (r_state == emfd_pkg::SQ_EMIT) && (!r_o_valid || !i_stall);
        w_div_req.start = (r_state == emfd_pkg::SQ_MUL) && w_en;
        w_div_req.num   = w_prod;
        w_div_req.den   = w_den;
    end

    emfd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= emfd_pkg::SQ_IDLE;
            r_pos     <= emfd_pkg::POS_HUNT;
            r_sum     <= 8'd0;
            r_last    <= 16'd0;
            r_energy  <= 48'd0;
            r_vgain   <= emfd_pkg::GAIN_RESET;
            r_igain   <= emfd_pkg::GAIN_RESET;
            r_pgain   <= emfd_pkg::GAIN_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // configuration writes; index three is ignored
            if (i_cfg_we) begin
                case (i_cfg_index)
                    emfd_pkg::CFG_VGAIN: r_vgain <= i_cfg_data;
                    emfd_pkg::CFG_IGAIN: r_igain <= i_cfg_data;
                    emfd_pkg::CFG_PGAIN: r_pgain <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // byte framing and checksum
            if (w_acc) begin
                if (w_hunt) begin
                    r_pos <= (i_rx_byte == emfd_pkg::HDR0) ? emfd_pkg::POS_HDR1
                                                           : emfd_pkg::POS_HUNT;
                end else if (r_pos == emfd_pkg::POS_HDR1) begin
                    r_pos <= w_bad_hdr ? emfd_pkg::POS_HUNT : emfd_pkg::POS_FIRST;
                    r_sum <= 8'd0;
                end else if (w_last) begin
                    r_pos <= emfd_pkg::POS_HUNT;
                end else begin
                    r_pos <= r_pos + 5'd1;
                    r_sum <= r_sum + i_rx_byte;
                end
            end

            // pulse counter and saturating energy total
            if (r_state == emfd_pkg::SQ_EMUL) begin
                r_last <= w_cnt;
            end
            if (r_state == emfd_pkg::SQ_EADD) begin
                r_energy <= w_esum[48] ? emfd_pkg::E_MAX : w_esum[47:0];
            end

            // output register
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        // data bytes shift into the frame store
        if (w_acc && !w_hunt && (r_pos >= emfd_pkg::POS_FIRST) && !w_last) begin
            r_sr[0] <= i_rx_byte;
            for (int k = 1; k < emfd_pkg::SR_LEN; k++) begin
                r_sr[k] <= r_sr[k-1];
            end
        end

        // frame end: status and cleared quantities
        if (w_acc && w_bad_hdr) begin
            r_status <= emfd_pkg::ST_BADHD;
            r_v      <= 32'd0;
            r_i      <= 32'd0;
            r_p      <= 32'd0;
        end else if (w_acc && w_last) begin
            r_status <= w_cs_ok ? emfd_pkg::ST_GOOD : emfd_pkg::ST_CKSUM;
            r_v      <= 32'd0;
            r_i      <= 32'd0;
            r_p      <= 32'd0;
            r_qty    <= emfd_pkg::QT_V;
        end

        // step through voltage, power, current
        if ((r_state == emfd_pkg::SQ_MUL) && !w_en) begin
            if (r_qty == emfd_pkg::QT_V) r_qty <= emfd_pkg::QT_P;
            else if (r_qty == emfd_pkg::QT_P) r_qty <= emfd_pkg::QT_I;
        end
        if ((r_state == emfd_pkg::SQ_DIV) && w_div_rsp.done) begin
            case (r_qty)
                emfd_pkg::QT_V: begin
                    r_v   <= w_div_rsp.quot;
                    r_qty <= emfd_pkg::QT_P;
                end
                emfd_pkg::QT_P: begin
                    r_p   <= w_div_rsp.quot;
                    r_qty <= emfd_pkg::QT_I;
                end
                emfd_pkg::QT_I: r_i <= w_div_rsp.quot;
                default: begin
                end
            endcase
        end

        if (r_state == emfd_pkg::SQ_EMUL) begin
            r_prod <= w_prod[39:0];
        end

        if (w_out_load) begin
            r_o_status <= r_status;
            r_o_v      <= r_v;
            r_o_i      <= r_i;
            r_o_p      <= r_p;
            r_o_energy <= r_energy;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_status  = r_o_status;
    assign o_voltage = r_o_v;
    assign o_current = r_o_i;
    assign o_power   = r_o_p;
    assign o_energy  = r_o_energy;

endmodule
